// ===== design/spk_pkg.sv =====
// Shared types and constants of the SPH pair kernel evaluator.
// No dependencies; used by every module of the block.
package spk_pkg;

	typedef enum logic [1:0] {
		CFG_RADIUS = 2'd0,
		CFG_POLY6  = 2'd1,
		CFG_SPIKY  = 2'd2,
		CFG_VISC   = 2'd3
	} cfg_idx_t;

	localparam logic [30:0] RADIUS_RST = 31'd65536;
	localparam logic [30:0] POLY6_RST  = 31'd102674;
	localparam logic [31:0] SPIKY_RST  = 32'hFFF1_AC64;   // -938908
	localparam logic [30:0] VISC_RST   = 31'd938908;

	localparam logic [63:0] CAP63 = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX31 = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MINMAG = 64'h0000_0000_8000_0000;

	// stage counts of the shared arithmetic units
	localparam int ROOT_LAT = 31;
	localparam int MUL_LAT  = 3;

endpackage

// ===== design/spk_mulsh.sv =====
// Pipelined 64x64 unsigned multiply, shift right by FRAC_BITS, hold at 2^63-1.
// Three stages: 32x32 partial products, middle sum, final add and clip. Uses spk_pkg.
module spk_mulsh #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0]  p00_s1, p01_s1, p10_s1, p11_s1;
	logic [64:0]  mid_s2;
	logic [63:0]  p00_s2, p11_s2;
	logic [127:0] full;
	logic [127:0] shifted;
	logic         cap;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
			mid_s2 <= 65'(p01_s1) + 65'(p10_s1);
			p00_s2 <= p00_s1;
			p11_s2 <= p11_s1;
			p      <= cap ? spk_pkg::CAP63 : shifted[63:0];
		end
	end

	always_comb begin
		full    = {p11_s2, p00_s2} + (128'(mid_s2) << 32);
		shifted = full >> FRAC_BITS;
		cap     = |full[127:FRAC_BITS+63];
	end

endmodule

// ===== design/spk_isqrt.sv =====
// Pipelined integer square root of a 62-bit value, one result bit per stage.
// Uses spk_pkg.
module spk_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] x,
	output logic [30:0] root
);

	localparam int N = spk_pkg::ROOT_LAT;

	logic [61:0] rem_s [N];
	logic [61:0] res_s [N];

	always_ff @(posedge clk) begin
		logic [61:0] rin, sin;
		logic [62:0] trial;
		logic [61:0] bitv;
		if (en) begin
			for (int k = 0; k < N; k++) begin
				rin   = (k == 0) ? x : rem_s[(k == 0) ? 0 : k-1];
				sin   = (k == 0) ? 62'd0 : res_s[(k == 0) ? 0 : k-1];
				bitv  = 62'd1 << (2 * (N - 1 - k));
				trial = 63'(sin) + 63'(bitv);
				if (63'(rin) >= trial) begin
					rem_s[k] <= 62'(63'(rin) - trial);
					res_s[k] <= (sin >> 1) + bitv;
				end else begin
					rem_s[k] <= rin;
					res_s[k] <= sin >> 1;
				end
			end
		end
	end

	assign root = res_s[N-1][30:0];

endmodule

// ===== design/sph_pair_kernel_eval.sv =====
// Top level of the SPH pair kernel evaluator: config registers, pipeline, output register.
// Uses spk_pkg, spk_mulsh and spk_isqrt.
//
// Usage: one pair displacement (x, y, z in signed Q16.16) enters on the s_axis channel
// and one result leaves on the m_axis channel: the poly6 density weight, the spiky
// gradient vector and the viscosity Laplacian, with an in-support and a clipped flag
// in m_axis_tuser. An item is taken in every cycle in which s_axis_tready is high.
// The square-root pipeline (one root bit per stage) and the divide pipelines that
// normalize the direction (one quotient bit per stage) set the depth of the pipeline.
// Throughput is one item per cycle while the receiver takes every result.
// The whole pipeline advances together: when the last stage holds a result that the
// receiver does not take, every stage holds and s_axis_tready is low, so nothing
// is lost or repeated. Registers are written through cfg_we/cfg_addr/cfg_data; the user
// must write them only while no item is in flight; the block does not enforce this.
// Reset empties the pipeline and loads the default radius (1.0) and coefficients.
module sph_pair_kernel_eval #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,   // disp_x, disp_y, disp_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// density_weight[30:0], grad_x, grad_y, grad_z, visc_lap[30:0], two zero bits
	output logic [159:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // in_support, saturated
);

	localparam int RS = 4 + spk_pkg::ROOT_LAT;        // root ready
	localparam int DSTEPS = FRAC_BITS + 1;
	localparam int US = RS + DSTEPS;                  // quotients ready
	localparam int MS = RS + 3 + spk_pkg::MUL_LAT;    // spiky magnitude ready
	localparam int GS = US + spk_pkg::MUL_LAT;        // gradient products ready
	localparam int FS = GS + 1;                       // output register
	localparam int WS = 4 + 3 * spk_pkg::MUL_LAT + 1; // clipped poly6 ready
	localparam int VS = RS + 3;                       // clipped viscosity ready

	logic [30:0] radius_q, poly6_q, visc_q;
	logic [31:0] spiky_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= spk_pkg::RADIUS_RST;
			poly6_q  <= spk_pkg::POLY6_RST;
			spiky_q  <= spk_pkg::SPIKY_RST;
			visc_q   <= spk_pkg::VISC_RST;
		end else if (cfg_we) begin
			case (spk_pkg::cfg_idx_t'(cfg_addr))
				spk_pkg::CFG_RADIUS: radius_q <= cfg_data[30:0];
				spk_pkg::CFG_POLY6:  poly6_q  <= cfg_data[30:0];
				spk_pkg::CFG_SPIKY:  spiky_q  <= cfg_data;
				spk_pkg::CFG_VISC:   visc_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	logic          en;
	logic [FS:1]   vld;

	assign en            = !vld[FS] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld[FS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[FS-1:1], s_axis_tvalid};
		end
	end

	// front: magnitudes, squares, squared distance, support test
	logic [31:0] ad_s   [3][1:RS];
	logic [2:0]  neg_s  [1:GS];
	logic [63:0] sq_s2  [3];
	logic [61:0] h2_s2, h2_s3;
	logic [63:0] d2_s3;
	logic [61:0] d2_s4;
	logic [61:0] q_s   [4:7];
	logic        sup_s [4:GS];
	logic        nz_s  [4:GS];

	always_ff @(posedge clk) begin
		logic [31:0] din;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				din = s_axis_tdata[32*i +: 32];
				ad_s[i][1] <= din[31] ? 32'(-din) : din;
				neg_s[1][i] <= din[31];
				for (int k = 2; k <= RS; k++) ad_s[i][k] <= ad_s[i][k-1];
				sq_s2[i] <= 64'(ad_s[i][1]) * 64'(ad_s[i][1]);
			end
			for (int k = 2; k <= GS; k++) neg_s[k] <= neg_s[k-1];
			h2_s2 <= 62'(radius_q) * 62'(radius_q);
			h2_s3 <= h2_s2;
			d2_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sup_s[4] <= d2_s3 < 64'(h2_s3);
			nz_s[4]  <= d2_s3 != 64'd0;
			q_s[4]   <= (h2_s3 - d2_s3[61:0]) >> FRAC_BITS;
			d2_s4    <= d2_s3[61:0];
			for (int k = 5; k <= 7; k++) q_s[k] <= q_s[k-1];
			for (int k = 5; k <= GS; k++) begin
				sup_s[k] <= sup_s[k-1];
				nz_s[k]  <= nz_s[k-1];
			end
		end
	end

	// poly6 branch: q^3 * c6
	logic [63:0] t1, t3, w64;
	logic [30:0] w_s    [WS:GS];
	logic        wsat_s [WS:GS];

	spk_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_qq (
		.clk(clk), .en(en), .a(64'(q_s[4])), .b(64'(q_s[4])), .p(t1));
	spk_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_qqq (
		.clk(clk), .en(en), .a(t1), .b(64'(q_s[7])), .p(t3));
	spk_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_c6 (
		.clk(clk), .en(en), .a(t3), .b(64'(poly6_q)), .p(w64));

	always_ff @(posedge clk) begin
		if (en) begin
			wsat_s[WS] <= w64 > spk_pkg::MAX31;
			w_s[WS]    <= (w64 > spk_pkg::MAX31) ? 31'h7FFF_FFFF : w64[30:0];
			for (int k = WS + 1; k <= GS; k++) begin
				w_s[k]    <= w_s[k-1];
				wsat_s[k] <= wsat_s[k-1];
			end
		end
	end

	// distance, spiky magnitude and viscosity
	logic [30:0] root;
	logic [30:0] e_s36;
	logic [61:0] esq_s37, vp_s37;
	logic [31:0] csabs;
	logic [63:0] m64;
	logic [63:0] m_s   [MS:US];
	logic [30:0] v_s   [VS:GS];
	logic        vsat_s [VS:GS];
	logic [61:0] vsh;

	spk_isqrt u_root (.clk(clk), .en(en), .x(d2_s4), .root(root));

	assign csabs = spiky_q[31] ? 32'(-spiky_q) : spiky_q;
	assign vsh   = vp_s37 >> FRAC_BITS;

	spk_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_cs (
		.clk(clk), .en(en), .a(64'(esq_s37 >> FRAC_BITS)), .b(64'(csabs)), .p(m64));

	always_ff @(posedge clk) begin
		if (en) begin
			e_s36   <= radius_q - root;
			esq_s37 <= 62'(e_s36) * 62'(e_s36);
			vp_s37  <= 62'(visc_q) * 62'(e_s36);
			vsat_s[VS] <= 64'(vsh) > spk_pkg::MAX31;
			v_s[VS]    <= (64'(vsh) > spk_pkg::MAX31) ? 31'h7FFF_FFFF : vsh[30:0];
			for (int k = VS + 1; k <= GS; k++) begin
				v_s[k]    <= v_s[k-1];
				vsat_s[k] <= vsat_s[k-1];
			end
			m_s[MS] <= m64;
			for (int k = MS + 1; k <= US; k++) m_s[k] <= m_s[k-1];
		end
	end

	// direction: |d_i| << F / r, one quotient bit per stage
	logic [30:0]        r_s   [DSTEPS];
	logic [30:0]        drem  [3][DSTEPS];
	logic [FRAC_BITS:0] dquo  [3][DSTEPS];

	always_ff @(posedge clk) begin
		logic [31:0]        part;
		logic [30:0]        rprev, remprev;
		logic [FRAC_BITS:0] qprev;
		logic               ge;
		if (en) begin
			for (int k = 0; k < DSTEPS; k++) begin
				rprev = (k == 0) ? root : r_s[(k == 0) ? 0 : k-1];
				r_s[k] <= rprev;
				for (int i = 0; i < 3; i++) begin
					remprev = (k == 0) ? ad_s[i][RS][31:1] : drem[i][(k == 0) ? 0 : k-1];
					qprev   = (k == 0) ? '0 : dquo[i][(k == 0) ? 0 : k-1];
					part    = {remprev, (k == 0) ? ad_s[i][RS][0] : 1'b0};
					ge      = part >= 32'(rprev);
					drem[i][k] <= ge ? 31'(part - 32'(rprev)) : part[30:0];
					dquo[i][k] <= {qprev[FRAC_BITS-1:0], ge};
				end
			end
		end
	end

	logic [63:0] gmag [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		spk_mulsh #(.FRAC_BITS(FRAC_BITS)) u_mul_g (
			.clk(clk), .en(en), .a(m_s[US]), .b(64'(dquo[i][DSTEPS-1])), .p(gmag[i]));
	end

	// final clip, gating and output register
	logic [31:0] g_c [3];
	logic [2:0]  gsat_c;
	logic        spk_on;
	logic [30:0] dens_q, visc_out_q;
	logic [31:0] g_q [3];
	logic        sup_q, sat_q;

	always_comb begin
		logic neg;
		spk_on = sup_s[GS] && nz_s[GS];
		for (int i = 0; i < 3; i++) begin
			neg = neg_s[GS][i] ^ spiky_q[31];
			g_c[i]    = '0;
			gsat_c[i] = 1'b0;
			if (spk_on && gmag[i] != 64'd0) begin
				if (neg) begin
					if (gmag[i] > spk_pkg::MINMAG) begin
						g_c[i]    = 32'h8000_0000;
						gsat_c[i] = 1'b1;
					end else begin
						g_c[i] = 32'(-gmag[i][31:0]);
					end
				end else if (gmag[i] > spk_pkg::MAX31) begin
					g_c[i]    = 32'h7FFF_FFFF;
					gsat_c[i] = 1'b1;
				end else begin
					g_c[i] = gmag[i][31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dens_q     <= sup_s[GS] ? w_s[GS] : '0;
			visc_out_q <= spk_on ? v_s[GS] : '0;
			for (int i = 0; i < 3; i++) g_q[i] <= g_c[i];
			sup_q <= sup_s[GS];
			sat_q <= (sup_s[GS] && wsat_s[GS]) || (spk_on && vsat_s[GS]) || (|gsat_c);
		end
	end

	assign m_axis_tdata = {2'b00, visc_out_q, g_q[2], g_q[1], g_q[0], dens_q};
	assign m_axis_tuser = {sat_q, sup_q};

	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("nonzero result outside support");

	a_sat_in_support: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("clip flag set outside support");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld))
		else $error("pipeline moved while stalled");

endmodule
